// ----- src/differential_drive_odometry_top_assert.svh -----
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH

// a holds at an edge, so b holds at the next one
`define ODO_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("odometry check failed: next-cycle relation");

// a never holds
`define ODO_ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("odometry check failed: forbidden condition");

`endif

// ----- src/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// Odometry package
// Payload types, register codes, fixed-point constants and series tables.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ANGLE_SH   = 32 - ANGLE_BITS;

  typedef struct packed {
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic [15:0]        heading_out;
    logic [15:0]        left_count_out;
    logic [15:0]        right_count_out;
  } odo_out_t;

  typedef struct packed {
    logic [31:0] count_scale;
    logic [11:0] wheel_base;
    logic [15:0] sim_speed;
    logic        sign_left;
    logic        sign_right;
    logic        frozen;
  } odo_cfg_t;

  // register indexes
  localparam logic [2:0] CFG_COUNT_SCALE = 3'd0;
  localparam logic [2:0] CFG_WHEEL_BASE  = 3'd1;
  localparam logic [2:0] CFG_SIM_SPEED   = 3'd2;
  localparam logic [2:0] CFG_SIGN_LEFT   = 3'd3;
  localparam logic [2:0] CFG_SIGN_RIGHT  = 3'd4;
  localparam logic [2:0] CFG_FROZEN      = 3'd5;

  localparam logic [31:0] RST_COUNT_SCALE = 32'd33554;
  localparam logic [11:0] RST_WHEEL_BASE  = 12'd300;
  localparam logic [15:0] RST_SIM_SPEED   = 16'd256;

  localparam logic [63:0]        INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [63:0]        PI_Q32         = 64'd13493037705;
  localparam logic [30:0]        ONE_Q30        = 31'd1073741824;
  localparam logic signed [63:0] TURN_EPS       = 64'sd1678;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        neg;
    logic [5:0]  sh;
    logic        rnd;
  } odo_mul_req_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        neg;
  } odo_div_req_t;

  // Horner divisors, sine series then cosine series
  function automatic logic [7:0] horner_k(input logic cos_sel, input logic [2:0] idx);
    logic [7:0] k;
    k = 8'd2;
    if (!cos_sel) begin
      case (idx)
        3'd0:    k = 8'd110;
        3'd1:    k = 8'd72;
        3'd2:    k = 8'd42;
        3'd3:    k = 8'd20;
        default: k = 8'd6;
      endcase
    end else begin
      case (idx)
        3'd0:    k = 8'd132;
        3'd1:    k = 8'd90;
        3'd2:    k = 8'd56;
        3'd3:    k = 8'd30;
        3'd4:    k = 8'd12;
        default: k = 8'd2;
      endcase
    end
    return k;
  endfunction

  // floor(2^32 / k) for the divisors above
  function automatic logic [31:0] horner_m(input logic cos_sel, input logic [2:0] idx);
    logic [31:0] m;
    m = 32'd2147483648;
    if (!cos_sel) begin
      case (idx)
        3'd0:    m = 32'd39045157;
        3'd1:    m = 32'd59652323;
        3'd2:    m = 32'd102261126;
        3'd3:    m = 32'd214748364;
        default: m = 32'd715827882;
      endcase
    end else begin
      case (idx)
        3'd0:    m = 32'd32537631;
        3'd1:    m = 32'd47721858;
        3'd2:    m = 32'd76695844;
        3'd3:    m = 32'd143165576;
        3'd4:    m = 32'd357913941;
        default: m = 32'd2147483648;
      endcase
    end
    return m;
  endfunction

endpackage

// ----- src/odo_mul.sv -----
// ----------------------------------------------------------------------------
// Odometry multiplier
// Sign-magnitude 64x64 multiply from four 32x32 partials, shift with optional rounding.
// ----------------------------------------------------------------------------
module odo_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  odo_pkg::odo_mul_req_t req,
  output logic                 done,
  output logic [63:0]          res
);

  logic         busy;
  logic [2:0]   cnt;
  logic         pv;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         neg_r;
  logic         rnd_r;
  logic [5:0]   sh_r;
  logic [127:0] acc;
  logic [63:0]  prod;
  logic [1:0]   pidx;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] prod_ext;
  logic [127:0] rsum;
  logic [127:0] rshift;

  always_comb begin
    a_half   = cnt[1] ? a_r[63:32] : a_r[31:0];
    b_half   = cnt[0] ? b_r[63:32] : b_r[31:0];
    prod_ext = {64'd0, prod} << {pidx[1] & pidx[0], pidx[1] ^ pidx[0], 5'd0};
    rsum     = acc + ((rnd_r && (sh_r != 6'd0)) ? (128'd1 << (sh_r - 6'd1)) : 128'd0);
    rshift   = rsum >> sh_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        pv   <= 1'b0;
      end else if (busy) begin
        pv  <= !cnt[2];
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      neg_r <= req.neg;
      rnd_r <= req.rnd;
      sh_r  <= req.sh;
      acc   <= '0;
    end else if (busy) begin
      if (!cnt[2]) begin
        prod <= a_half * b_half;
        pidx <= cnt[1:0];
      end
      if (pv) acc <= acc + prod_ext;
      if (cnt == 3'd5) res <= neg_r ? (64'd0 - rshift[63:0]) : rshift[63:0];
    end
  end

endmodule

// ----- src/odo_div.sv -----
// ----------------------------------------------------------------------------
// Odometry divider
// Radix-2 restoring divide, 64 bits, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module odo_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  odo_pkg::odo_div_req_t req,
  output logic                 done,
  output logic [63:0]          res
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] den_r;
  logic        neg_r;
  logic [64:0] rem_sh;
  logic [65:0] sub;
  logic        ge;

  always_comb begin
    rem_sh = {rem, quo[63]};
    sub    = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !sub[65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt[6]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= req.num;
      den_r <= req.den;
      neg_r <= req.neg;
    end else if (busy) begin
      if (!cnt[6]) begin
        rem <= ge ? sub[63:0] : rem_sh[63:0];
        quo <= {quo[62:0], ge};
      end else begin
        res <= neg_r ? (64'd0 - quo) : quo;
      end
    end
  end

endmodule

// ----- src/odo_core.sv -----
// ----------------------------------------------------------------------------
// Odometry core
// Sequencer over the shared multiplier and divider; holds the pose.
// ----------------------------------------------------------------------------
module odo_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  odo_pkg::odo_in_t  in_data,
  input  odo_pkg::odo_cfg_t cfg,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output odo_pkg::odo_out_t res
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CNT_L = 5'd1;
  localparam logic [4:0] ST_CNT_R = 5'd2;
  localparam logic [4:0] ST_TL    = 5'd3;
  localparam logic [4:0] ST_TR    = 5'd4;
  localparam logic [4:0] ST_DIVQ  = 5'd5;
  localparam logic [4:0] ST_PH    = 5'd6;
  localparam logic [4:0] SC_PRE   = 5'd7;
  localparam logic [4:0] SC_X     = 5'd8;
  localparam logic [4:0] SC_X2    = 5'd9;
  localparam logic [4:0] SC_HM    = 5'd10;
  localparam logic [4:0] SC_HR    = 5'd11;
  localparam logic [4:0] SC_HK    = 5'd12;
  localparam logic [4:0] SC_S     = 5'd13;
  localparam logic [4:0] SC_END   = 5'd14;
  localparam logic [4:0] ST_SINC  = 5'd15;
  localparam logic [4:0] ST_TX    = 5'd16;
  localparam logic [4:0] ST_DX    = 5'd17;
  localparam logic [4:0] ST_TY    = 5'd18;
  localparam logic [4:0] ST_DY    = 5'd19;
  localparam logic [4:0] ST_SX    = 5'd20;
  localparam logic [4:0] ST_SY    = 5'd21;
  localparam logic [4:0] ST_UPD   = 5'd22;
  localparam logic [4:0] ST_DONE  = 5'd23;

  logic [4:0]  state;
  logic        issued;
  logic        first_step;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [odo_pkg::ANGLE_BITS-1:0] heading;
  logic [15:0] left_count;
  logic [15:0] right_count;

  logic signed [15:0] spd_l;
  logic signed [15:0] spd_r;
  logic signed [15:0] dl;
  logic signed [15:0] dr;
  logic [63:0] tl;
  logic [63:0] sum2;
  logic [63:0] diff;
  logic [63:0] q;
  logic [63:0] ph;
  logic [63:0] tt;
  logic [63:0] sinc;
  logic [63:0] dx;
  logic [63:0] dy;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [31:0] hs;

  // sine/cosine sub-sequence
  logic        sc_half;
  logic        sc_csel;
  logic        sc_swap;
  logic [1:0]  sc_quad;
  logic [29:0] sc_r;
  logic [30:0] sc_x;
  logic [30:0] sc_x2;
  logic [30:0] sc_t;
  logic [30:0] sc_n;
  logic [30:0] sc_q0;
  logic [30:0] sc_s;
  logic [2:0]  sc_k;

  odo_pkg::odo_mul_req_t mreq;
  odo_pkg::odo_div_req_t dreq;
  logic        op_mul;
  logic        op_div;
  logic        mul_start;
  logic        div_start;
  logic        mdone;
  logic        ddone;
  logic [63:0] mres;
  logic [63:0] dres;
  logic        op_done;

  logic [11:0] base;
  logic [31:0] sc_p;
  logic [7:0]  hk_k;
  logic [30:0] hk_rem;
  logic [30:0] hk_q;
  logic        hk_last;
  logic [30:0] sv;
  logic [30:0] cv;
  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;
  logic        big_turn;
  logic [31:0] dth_full;
  logic [odo_pkg::ANGLE_BITS+15:0] head_x;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  odo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mreq),
    .done  (mdone),
    .res   (mres)
  );

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (dreq),
    .done  (ddone),
    .res   (dres)
  );

  always_comb begin
    base     = (cfg.wheel_base == 12'd0) ? 12'd1 : cfg.wheel_base;
    sc_p     = ph[32:1] + (sc_half ? 32'd0 : (32'(heading) << odo_pkg::ANGLE_SH));
    hk_k     = odo_pkg::horner_k(sc_csel, sc_k);
    hk_rem   = sc_n - mres[30:0];
    hk_q     = sc_q0 + 31'(hk_rem >= 31'(hk_k));
    hk_last  = sc_csel ? (sc_k == 3'd5) : (sc_k == 3'd4);
    big_turn = ($signed(q) >= odo_pkg::TURN_EPS) || ($signed(q) <= -odo_pkg::TURN_EPS);
    dth_full = ph[31:0] + (32'd1 << (odo_pkg::ANGLE_SH - 1));
    head_x   = {heading, 16'd0};
    sv       = sc_swap ? sc_t : sc_s;
    cv       = sc_swap ? sc_s : sc_t;
    case (sc_quad)
      2'd0:    begin sin_v = 32'(sv);         cos_v = 32'(cv);         end
      2'd1:    begin sin_v = 32'(cv);         cos_v = 32'd0 - 32'(sv); end
      2'd2:    begin sin_v = 32'd0 - 32'(sv); cos_v = 32'd0 - 32'(cv); end
      default: begin sin_v = 32'd0 - 32'(cv); cos_v = 32'(sv);         end
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mreq   = '0;
    dreq   = '0;
    op_mul = 1'b0;
    op_div = 1'b0;
    unique case (state) inside
      ST_CNT_L: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(cfg.sim_speed);
        mreq.b   = mag64(64'(spd_l));
        mreq.neg = spd_l[15] ^ cfg.sign_left;
        mreq.sh  = 6'd8;
      end
      ST_CNT_R: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(cfg.sim_speed);
        mreq.b   = mag64(64'(spd_r));
        mreq.neg = spd_r[15] ^ cfg.sign_right;
        mreq.sh  = 6'd8;
      end
      ST_TL: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(64'(dl));
        mreq.b   = 64'(cfg.count_scale);
        mreq.neg = dl[15] ^ cfg.sign_left;
      end
      ST_TR: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(64'(dr));
        mreq.b   = 64'(cfg.count_scale);
        mreq.neg = dr[15] ^ cfg.sign_right;
      end
      ST_DIVQ: begin
        op_div   = 1'b1;
        dreq.num = mag64(diff);
        dreq.den = 64'(base);
        dreq.neg = diff[63];
      end
      ST_PH: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(q);
        mreq.b   = odo_pkg::INV_TWO_PI_Q32;
        mreq.neg = q[63];
        mreq.sh  = 6'd24;
        mreq.rnd = 1'b1;
      end
      SC_X: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_r);
        mreq.b   = odo_pkg::PI_Q32;
        mreq.sh  = 6'd33;
        mreq.rnd = 1'b1;
      end
      SC_X2: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_x);
        mreq.b   = 64'(sc_x);
        mreq.sh  = 6'd30;
        mreq.rnd = 1'b1;
      end
      SC_HM: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_x2);
        mreq.b   = 64'(sc_t);
        mreq.sh  = 6'd30;
      end
      SC_HR: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_n);
        mreq.b   = 64'(odo_pkg::horner_m(sc_csel, sc_k));
        mreq.sh  = 6'd32;
      end
      SC_HK: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_q0);
        mreq.b   = 64'(hk_k);
      end
      SC_S: begin
        op_mul   = 1'b1;
        mreq.a   = 64'(sc_x);
        mreq.b   = 64'(sc_t);
        mreq.sh  = 6'd30;
      end
      ST_SINC: begin
        op_div   = 1'b1;
        dreq.num = mag64(64'(hs)) << 25;
        dreq.den = mag64(q);
        dreq.neg = hs[31] ^ q[63];
      end
      ST_TX, ST_SX: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(sum2);
        mreq.b   = mag64(64'(cs));
        mreq.neg = sum2[63] ^ cs[31];
        mreq.sh  = (state == ST_TX) ? 6'd30 : 6'd47;
        mreq.rnd = 1'b1;
      end
      ST_TY, ST_SY: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(sum2);
        mreq.b   = mag64(64'(sn));
        mreq.neg = sum2[63] ^ sn[31];
        mreq.sh  = (state == ST_TY) ? 6'd30 : 6'd47;
        mreq.rnd = 1'b1;
      end
      ST_DX, ST_DY: begin
        op_mul   = 1'b1;
        mreq.a   = mag64(tt);
        mreq.b   = mag64(sinc);
        mreq.neg = tt[63] ^ sinc[63];
        mreq.sh  = 6'd47;
        mreq.rnd = 1'b1;
      end
      default: begin
        op_mul = 1'b0;
      end
    endcase
  end

  assign mul_start = op_mul && !issued;
  assign div_start = op_div && !issued;
  assign op_done   = issued && (op_mul ? mdone : ddone);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      first_step  <= 1'b1;
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= '0;
      left_count  <= '0;
      right_count <= '0;
    end else begin
      if (mul_start || div_start) issued <= 1'b1;
      if (op_done) issued <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            spd_l <= in_data.speed_left;
            spd_r <= in_data.speed_right;
            state <= cfg.frozen ? ST_DONE : ST_CNT_L;
          end
        end
        ST_CNT_L: begin
          if (op_done) begin
            left_count <= left_count + mres[15:0];
            dl         <= mres[15:0];
            state      <= ST_CNT_R;
          end
        end
        ST_CNT_R: begin
          if (op_done) begin
            right_count <= right_count + mres[15:0];
            dr          <= mres[15:0];
            if (first_step) begin
              first_step <= 1'b0;
              state      <= ST_DONE;
            end else begin
              state <= ST_TL;
            end
          end
        end
        ST_TL: begin
          if (op_done) begin
            tl    <= mres;
            state <= ST_TR;
          end
        end
        ST_TR: begin
          if (op_done) begin
            sum2  <= mres + tl;
            diff  <= mres - tl;
            state <= ST_DIVQ;
          end
        end
        ST_DIVQ: begin
          if (op_done) begin
            q     <= dres;
            state <= ST_PH;
          end
        end
        ST_PH: begin
          if (op_done) begin
            ph      <= mres;
            sc_half <= 1'b0;
            state   <= SC_PRE;
          end
        end
        SC_PRE: begin
          // fold the phase into the first octant
          sc_quad <= sc_p[31:30];
          sc_swap <= sc_p[29];
          sc_r    <= sc_p[29] ? 30'(31'd1073741824 - 31'(sc_p[29:0])) : sc_p[29:0];
          state   <= SC_X;
        end
        SC_X: begin
          if (op_done) begin
            sc_x  <= mres[30:0];
            state <= SC_X2;
          end
        end
        SC_X2: begin
          if (op_done) begin
            sc_x2   <= mres[30:0];
            sc_t    <= odo_pkg::ONE_Q30;
            sc_k    <= 3'd0;
            sc_csel <= 1'b0;
            state   <= SC_HM;
          end
        end
        SC_HM: begin
          if (op_done) begin
            sc_n  <= mres[30:0];
            state <= SC_HR;
          end
        end
        SC_HR: begin
          if (op_done) begin
            sc_q0 <= mres[30:0];
            state <= SC_HK;
          end
        end
        SC_HK: begin
          if (op_done) begin
            sc_t <= odo_pkg::ONE_Q30 - hk_q;
            sc_k <= sc_k + 3'd1;
            if (hk_last) state <= sc_csel ? SC_END : SC_S;
            else state <= SC_HM;
          end
        end
        SC_S: begin
          if (op_done) begin
            sc_s    <= mres[30:0];
            sc_csel <= 1'b1;
            sc_t    <= odo_pkg::ONE_Q30;
            sc_k    <= 3'd0;
            state   <= SC_HM;
          end
        end
        SC_END: begin
          if (sc_half) begin
            hs    <= sin_v;
            state <= ST_SINC;
          end else begin
            sn <= sin_v;
            cs <= cos_v;
            if (big_turn) begin
              sc_half <= 1'b1;
              state   <= SC_PRE;
            end else begin
              state <= ST_SX;
            end
          end
        end
        ST_SINC: begin
          if (op_done) begin
            sinc  <= dres;
            state <= ST_TX;
          end
        end
        ST_TX: begin
          if (op_done) begin
            tt    <= mres;
            state <= ST_DX;
          end
        end
        ST_DX: begin
          if (op_done) begin
            dx    <= mres;
            state <= ST_TY;
          end
        end
        ST_TY: begin
          if (op_done) begin
            tt    <= mres;
            state <= ST_DY;
          end
        end
        ST_DY: begin
          if (op_done) begin
            dy    <= mres;
            state <= ST_UPD;
          end
        end
        ST_SX: begin
          if (op_done) begin
            dx    <= mres;
            state <= ST_SY;
          end
        end
        ST_SY: begin
          if (op_done) begin
            dy    <= mres;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          pos_x   <= pos_x + dx[31:0];
          pos_y   <= pos_y + dy[31:0];
          heading <= heading + dth_full[31 -: odo_pkg::ANGLE_BITS];
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.pos_x_out       = pos_x;
    res.pos_y_out       = pos_y;
    res.heading_out     = head_x[odo_pkg::ANGLE_BITS +: 16];
    res.left_count_out  = left_count;
    res.right_count_out = right_count;
  end

endmodule

// ----- src/differential_drive_odometry_top.sv -----
// ----------------------------------------------------------------------------
// Differential-drive odometry, top level
// Dead reckoning from wheel speed commands: encoder counts and pose update.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one request per tick, left and right speed commands.
//   out channel : one result per request, pose (x, y in Q24.8 mm, heading as
//                 a 16-bit binary angle) and both 16-bit encoder counts.
//   cfg channel : register writes, always ready; write only while idle.
// Throughput: one request at a time. The first tick runs only the two count
//   products and a frozen tick runs none. Other steps are paced by the one
//   shared 64-bit multiplier (81 products for a turning step, 43 for a
//   near-straight one) and the radix-2 divider (used once or twice).
// Stall: the finished result moves into the output register; a new request
//   is accepted as soon as the core is idle, even while the receiver holds
//   off. The core waits only if the output register is still occupied.
// Reset: counts and pose clear, registers take their defaults, the next
//   tick is treated as the first one (zero travel).
// ----------------------------------------------------------------------------
module differential_drive_odometry_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  odo_pkg::odo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output odo_pkg::odo_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  odo_pkg::odo_cfg_t cfg;
  odo_pkg::odo_out_t core_res;
  logic              core_idle;
  logic              res_valid;
  logic              res_take;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_scale <= odo_pkg::RST_COUNT_SCALE;
      cfg.wheel_base  <= odo_pkg::RST_WHEEL_BASE;
      cfg.sim_speed   <= odo_pkg::RST_SIM_SPEED;
      cfg.sign_left   <= 1'b1;
      cfg.sign_right  <= 1'b0;
      cfg.frozen      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        odo_pkg::CFG_COUNT_SCALE: cfg.count_scale <= cfg_data;
        odo_pkg::CFG_WHEEL_BASE:  cfg.wheel_base  <= cfg_data[11:0];
        odo_pkg::CFG_SIM_SPEED:   cfg.sim_speed   <= cfg_data[15:0];
        odo_pkg::CFG_SIGN_LEFT:   cfg.sign_left   <= cfg_data[0];
        odo_pkg::CFG_SIGN_RIGHT:  cfg.sign_right  <= cfg_data[0];
        odo_pkg::CFG_FROZEN:      cfg.frozen      <= cfg_data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // request accepted whenever the sequencer is parked
  assign in_ready = core_idle;

  odo_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (core_res)
  );

  // result hands over once the output register is empty or draining
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data <= core_res;
  end

`include "differential_drive_odometry_top_assert.svh"

  `ODO_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `ODO_ASSERT_NEXT(a_take_loads, res_take, out_valid && (out_data == $past(core_res)))
  `ODO_ASSERT_NEVER(a_ready_vs_result, in_ready && res_valid)

endmodule
